>>> sv/csth_pkg.sv
// types, codes and constants for the connection slot table
`default_nettype none

package csth_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 128;
  localparam logic [15:0] HOLD_RESET      = 16'd240;
  localparam int unsigned SLOT_W          = 7;

  localparam logic REQ_OPEN  = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  localparam logic [1:0] STATUS_GRANT   = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_STAMPED = 2'd2;
  localparam logic [1:0] STATUS_NOMATCH = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] peer_port;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  typedef struct packed {
    logic        active;
    logic [15:0] port;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/connection_slot_table_with_hold_unit.sv
// connection slot table with hold time: slot memory, scan sequencer and result register
//
// Usage: an input word on in_valid/in_stall carries an open or close request with the
// peer port and the current time. Each word yields exactly one result word on
// out_valid/out_stall with a status code and a slot index. cfg_wr_en/cfg_wr_data write
// the hold time (reset value 240); the user must write it only while the block is idle.
// The table lives in one single-port-per-side memory of TABLE_SLOTS entries. The
// sequencer visits one slot at a time (read, then compare and write back). An open
// scans every slot before its result is loaded; a close stops at the first matching
// slot, or scans every slot when there is no match.
// One word is in work at a time; in_stall is high until the result is handed to the
// output register, and the next word is taken in the cycle after. The output register
// holds a result while out_stall is high and a new word may be accepted and scanned
// meanwhile; the scan then waits before loading.
// After reset a clearing pass marks every slot inactive, one slot per cycle, with
// in_stall high; configuration writes are taken throughout, as the block itself has no idle check.
`default_nettype none

module connection_slot_table_with_hold_unit #(
  parameter int unsigned TABLE_SLOTS = csth_pkg::TABLE_SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire [15:0]          cfg_wr_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  csth_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output csth_pkg::out_word_t out_word
);
  import csth_pkg::*;

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  entry_t mem [TABLE_SLOTS];
  entry_t rd_data_r;

  state_t    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  in_word_t  req_r, req_nxt;
  logic      found_r, found_nxt;
  out_word_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic [15:0] hold_r;

  logic      mem_we;
  entry_t    mem_wd;

  logic          last_slot;
  logic [31:0]   age;
  logic          expired;
  logic          slot_free;
  logic          port_hit;
  logic [SLOT_W+IW-1:0] idx_wide;
  logic [SLOT_W-1:0]    idx_slot;

  // shared compare unit
  assign last_slot = (idx_r == IW'(TABLE_SLOTS - 1));
  assign age       = req_r.now_time - rd_data_r.stamp;
  assign expired   = rd_data_r.active && (age > {16'd0, hold_r});
  assign slot_free = !rd_data_r.active || expired;
  assign port_hit  = rd_data_r.active && (rd_data_r.port == req_r.peer_port);
  assign idx_wide  = (SLOT_W + IW)'(idx_r);
  assign idx_slot  = idx_wide[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wd;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hold_r      <= HOLD_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        hold_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wd        = rd_data_r;
    in_stall      = 1'b1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_wd        = '0;
        if (last_slot) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt    = in_word;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          res_nxt.slot   = '0;
          res_nxt.status = (in_word.req_type == REQ_OPEN) ? STATUS_FULL : STATUS_NOMATCH;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (req_r.req_type == REQ_OPEN) begin
          if (!found_r && slot_free) begin
            mem_we         = 1'b1;
            mem_wd.active  = 1'b1;
            mem_wd.port    = req_r.peer_port;
            mem_wd.stamp   = '0;
            found_nxt      = 1'b1;
            res_nxt.status = STATUS_GRANT;
            res_nxt.slot   = idx_slot;
          end else if (expired) begin
            mem_we        = 1'b1;
            mem_wd.active = 1'b0;
          end
          if (last_slot) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          if (port_hit) begin
            mem_we         = 1'b1;
            mem_wd.stamp   = req_r.now_time;
            res_nxt.status = STATUS_STAMPED;
            res_nxt.slot   = idx_slot;
            state_nxt      = S_DONE;
          end else if (last_slot) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          idx_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> sim/connection_slot_table_with_hold_unit_test.sv
// testbench for the connection slot table with hold time: directed and random requests
module connection_slot_table_with_hold_unit_test;
  import csth_pkg::*;

  localparam int unsigned SLOTS           = TABLE_SLOTS_DEF;
  localparam int unsigned POOL            = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES    = 2 * SLOTS + 40;
  localparam int unsigned CYCLE_LIMIT     = 5_000_000;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // table state as seen by the checker
  bit          slot_busy  [SLOTS];
  logic [15:0] slot_port  [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [15:0] hold_secs = HOLD_RESET;

  out_word_t   pending_replies[$];
  logic [31:0] clock_now;
  logic [15:0] port_pool[POOL];
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  connection_slot_table_with_hold_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t   r;
    logic [31:0] age;
    bit          done;
    done = 1'b0;
    r.slot = '0;
    if (w.req_type == REQ_OPEN) begin
      r.status = STATUS_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        age = w.now_time - slot_stamp[i];
        if (slot_busy[i] && age > {16'd0, hold_secs}) slot_busy[i] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && !slot_busy[i]) begin
          slot_busy[i]  = 1'b1;
          slot_port[i]  = w.peer_port;
          slot_stamp[i] = '0;
          r.status = STATUS_GRANT;
          r.slot   = SLOT_W'(i);
          done     = 1'b1;
        end
      end
    end else begin
      r.status = STATUS_NOMATCH;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && slot_busy[i] && slot_port[i] == w.peer_port) begin
          slot_stamp[i] = w.now_time;
          r.status = STATUS_STAMPED;
          r.slot   = SLOT_W'(i);
          done     = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit allowed);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (!allowed || roll < 50) return 0;
    if (roll < 94) return $urandom_range(4, 1);
    return $urandom_range(300, 20);
  endfunction

  function automatic in_word_t make_req(logic kind, logic [15:0] port, logic [31:0] now);
    in_word_t w;
    w.req_type  = kind;
    w.peer_port = port;
    w.now_time  = now;
    return w;
  endfunction

  function automatic in_word_t next_request(int unsigned step_max, int unsigned open_pct,
                                            int unsigned noise_pct);
    in_word_t w;
    w.req_type = ($urandom_range(99, 0) < open_pct) ? REQ_OPEN : REQ_CLOSE;
    if ($urandom_range(99, 0) < noise_pct) begin
      w.peer_port = 16'($urandom);
      w.now_time  = $urandom;
    end else begin
      clock_now   = clock_now + $urandom_range(step_max, 0);
      w.peer_port = port_pool[$urandom_range(POOL - 1, 0)];
      w.now_time  = clock_now;
    end
    return w;
  endfunction

  function automatic void flag_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  task automatic refresh_ports();
    for (int i = 0; i < POOL; i++) port_pool[i] = 16'($urandom);
  endtask

  task automatic offer_request(in_word_t w);
    int unsigned gap;
    gap = pick_gap(send_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_request(w));
  endtask

  task automatic await_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic write_hold(logic [15:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hold_secs = value;
  endtask

  task automatic run_phase(int unsigned count, int unsigned step_max, int unsigned open_pct,
                           int unsigned noise_pct);
    for (int unsigned k = 0; k < count; k++)
      offer_request(next_request(step_max, open_pct, noise_pct));
  endtask

  // runs on the reset hold time
  task automatic test_directed();
    offer_request(make_req(REQ_CLOSE, 16'h0000, 32'h0000_0000));
    offer_request(make_req(REQ_OPEN,  16'h0000, 32'h0000_0000));
    offer_request(make_req(REQ_OPEN,  16'hFFFF, 32'h0000_000A));
    offer_request(make_req(REQ_OPEN,  16'hFFFF, 32'h0000_0014));
    offer_request(make_req(REQ_CLOSE, 16'hFFFF, 32'h0000_0064));
    offer_request(make_req(REQ_CLOSE, 16'hFFFF, 32'h0000_006E));
    offer_request(make_req(REQ_OPEN,  16'h5A5A, 32'h0000_00F0));
    offer_request(make_req(REQ_OPEN,  16'hA5A5, 32'h0000_00F1));
    offer_request(make_req(REQ_CLOSE, 16'h5A5A, 32'h0000_012C));
    offer_request(make_req(REQ_CLOSE, 16'hFFFF, 32'h0000_015F));
    offer_request(make_req(REQ_OPEN,  16'h1234, 32'hFFFF_FFFF));
    offer_request(make_req(REQ_CLOSE, 16'h1234, 32'hFFFF_FFF0));
    offer_request(make_req(REQ_OPEN,  16'h8001, 32'h0000_0010));
    offer_request(make_req(REQ_CLOSE, 16'h8001, 32'h7FFF_FFFF));
    offer_request(make_req(REQ_OPEN,  16'h7FFE, 32'h8000_0000));
    offer_request(make_req(REQ_CLOSE, 16'hA5A5, 32'h8000_0000));
    await_replies();
  endtask

  task automatic test_zero_hold();
    write_hold(16'h0000);
    refresh_ports();
    clock_now = $urandom;
    run_phase(60, 2, 50, 5);
    await_replies();
  endtask

  // unclosed slots keep stamp zero, so a low clock fills the table
  task automatic test_table_full();
    write_hold(16'hFFFF);
    refresh_ports();
    clock_now = '0;
    run_phase(170, 3, 90, 0);
    clock_now = 32'h0000_FFFF;
    run_phase(10, 1, 50, 0);
    await_replies();
  endtask

  task automatic test_backpressure();
    send_idle    = 1'b0;
    hold_off_req = 1'b1;
    run_phase(8, 20, 50, 0);
    send_idle    = 1'b1;
    await_replies();
  endtask

  task automatic test_random_holds();
    logic [15:0] hold;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: hold = 16'($urandom);
        1: hold = 16'($urandom_range(30, 1));
        2: hold = HOLD_RESET;
        default: hold = 16'($urandom_range(600, 100));
      endcase
      write_hold(hold);
      refresh_ports();
      send_idle = (p != 3);
      recv_idle = (p != 3 && p != 6);
      clock_now = $urandom;
      run_phase(125, (p % 2) ? 40 : 400, 55, 10);
      await_replies();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin : out_stall_driver
    int unsigned hold_left;
    int unsigned run_left;
    hold_left = 0;
    run_left  = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        out_stall <= recv_idle && ($urandom_range(1, 0) == 1);
        run_left = pick_gap(recv_idle);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        flag_failure($sformatf("unexpected word: status %0d slot %0d",
                               out_word.status, out_word.slot));
      end else begin
        want = pending_replies.pop_front();
        if (out_word.status !== want.status)
          flag_failure($sformatf("status mismatch: expected %0d, got %0d",
                                 want.status, out_word.status));
        if (out_word.slot !== want.slot)
          flag_failure($sformatf("slot mismatch: expected %0d, got %0d",
                                 want.slot, out_word.slot));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("connection_slot_table_with_hold_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_hold();
    test_table_full();
    test_backpressure();
    test_random_holds();
    await_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("connection_slot_table_with_hold_unit_test OK");
    end else begin
      $display("connection_slot_table_with_hold_unit_test NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/csth_pkg.sv
sv/connection_slot_table_with_hold_unit.sv
sim/connection_slot_table_with_hold_unit_test.sv
